// ===== rtl/rgbx_pkg.sv =====
// Package: palette constants, candidate types and helper functions for the xterm-256 quantizer.
`default_nettype none
package rgbx_pkg;

  localparam int CH_W      = 8;
  localparam int IDX_W     = 8;
  localparam int DIST_W    = 18;   // 3*255*255 fits
  localparam int SQ_W      = 16;
  localparam int SUM_W     = 10;
  localparam int T_W       = 20;   // signed offset term, see stage 3
  localparam int LVL_W     = 3;

  localparam int SYS_N     = 16;
  localparam int GREY_N    = 24;
  localparam int CAND_N    = SYS_N + 1 + GREY_N;   // system, best cube entry, greys
  localparam int TREE_N    = 64;
  localparam int CUBE_SLOT = SYS_N;
  localparam int GREY_SLOT = SYS_N + 1;

  localparam int CUBE_BASE = 16;
  localparam int GREY_BASE = 232;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef struct packed {
    dist_t dist_sq;
    idx_t  idx;
  } cand_t;

  // System colors 0..15 as 0xRRGGBB
  function automatic logic [23:0] sys_color(input logic [3:0] i);
    logic [23:0] c;
    unique case (i)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'h800000;
      4'd2:  c = 24'h008000;
      4'd3:  c = 24'h808000;
      4'd4:  c = 24'h000080;
      4'd5:  c = 24'h800080;
      4'd6:  c = 24'h008080;
      4'd7:  c = 24'hc0c0c0;
      4'd8:  c = 24'h808080;
      4'd9:  c = 24'hff0000;
      4'd10: c = 24'h00ff00;
      4'd11: c = 24'hffff00;
      4'd12: c = 24'h0000ff;
      4'd13: c = 24'hff00ff;
      4'd14: c = 24'h00ffff;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

  function automatic chan_t cube_level(input lvl_t k);
    chan_t v;
    unique case (k)
      3'd0: v = 8'h00;
      3'd1: v = 8'h5f;
      3'd2: v = 8'h87;
      3'd3: v = 8'haf;
      3'd4: v = 8'hd7;
      default: v = 8'hff;
    endcase
    return v;
  endfunction

  // Nearest cube level per channel; midpoints resolve toward the lower level.
  function automatic lvl_t cube_sel(input chan_t c);
    lvl_t k;
    priority if (c <= 8'd47)  k = 3'd0;
    else if (c <= 8'd115)     k = 3'd1;
    else if (c <= 8'd155)     k = 3'd2;
    else if (c <= 8'd195)     k = 3'd3;
    else if (c <= 8'd235)     k = 3'd4;
    else                      k = 3'd5;
    return k;
  endfunction

  function automatic int grey_level(input int k);
    return 8 + 10 * k;
  endfunction

  // Keeps the left (lower index) candidate on equal distance.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.dist_sq < a.dist_sq) ? b : a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rgb_to_xterm256_nearest_unit.sv =====
// Top level: pipelined nearest-color search over the xterm 256-color palette.
//
//   channel   ports                               handshake
//   input     in_red, in_green, in_blue           start && !busy
//   result    out_palette_index                   out_valid, one cycle
//
// One item per cycle while busy is low. An item passes seven register stages:
// input, squares and cube level pick, offset terms, candidate distances, then a
// 64-leaf min tree in three stages of two levels each; the last stage drives
// out_palette_index. busy is high only while in reset and the cycle after it;
// reset clears the valid bits and drops any item in flight. The receiver cannot
// stall, so nothing else holds the pipe.
`default_nettype none
module rgb_to_xterm256_nearest_unit
  import rgbx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  output logic [7:0]       out_palette_index
);

  localparam int STAGES = 7;

  logic              busy_r;
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic              accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // stage 1: input capture
  chan_t s1_c_r [3];

  // stage 2: squares, channel sum, nearest cube level and its offset
  logic [SQ_W-1:0]  s2_sq_r   [3];
  logic [SQ_W-1:0]  s2_sq_nxt [3];
  logic [SUM_W-1:0] s2_sum_r, s2_sum_nxt;
  lvl_t             s2_sel_r  [3];
  lvl_t             s2_sel_nxt[3];
  chan_t            s2_dif_r  [3];
  chan_t            s2_dif_nxt[3];
  chan_t            s2_c_r    [3];

  // stage 3: |c|^2, cube distance, and per system and grey candidate |E|^2 - 2 c.E
  dist_t                  s3_q_r, s3_q_nxt;
  cand_t                  s3_cube_r, s3_cube_nxt;
  logic signed [T_W-1:0]  s3_t_r   [SYS_N+GREY_N];
  logic signed [T_W-1:0]  s3_t_nxt [SYS_N+GREY_N];

  // stage 4: candidate distances in palette order
  cand_t s4_cand_r   [CAND_N];
  cand_t s4_cand_nxt [CAND_N];

  // stages 5..7: min tree
  cand_t s5_r [16];
  cand_t s5_nxt [16];
  cand_t s6_r [4];
  cand_t s6_nxt [4];
  cand_t s7_r, s7_nxt;
  cand_t leaf [TREE_N];

  always_comb begin
    vld_nxt = {vld_r[STAGES-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  always_comb begin
    chan_t lv;
    for (int ch = 0; ch < 3; ch++) begin
      s2_sq_nxt[ch]  = SQ_W'(s1_c_r[ch]) * SQ_W'(s1_c_r[ch]);
      s2_sel_nxt[ch] = cube_sel(s1_c_r[ch]);
      lv             = cube_level(s2_sel_nxt[ch]);
      s2_dif_nxt[ch] = (s1_c_r[ch] >= lv) ? chan_t'(s1_c_r[ch] - lv) : chan_t'(lv - s1_c_r[ch]);
    end
    s2_sum_nxt = SUM_W'(s1_c_r[0]) + SUM_W'(s1_c_r[1]) + SUM_W'(s1_c_r[2]);
  end

  always_comb begin
    logic [23:0] e;
    int          dot;
    int          k2;
    int          v;
    s3_q_nxt = DIST_W'(s2_sq_r[0]) + DIST_W'(s2_sq_r[1]) + DIST_W'(s2_sq_r[2]);
    s3_cube_nxt.dist_sq = DIST_W'(s2_dif_r[0]) * DIST_W'(s2_dif_r[0])
                        + DIST_W'(s2_dif_r[1]) * DIST_W'(s2_dif_r[1])
                        + DIST_W'(s2_dif_r[2]) * DIST_W'(s2_dif_r[2]);
    s3_cube_nxt.idx  = IDX_W'(CUBE_BASE + 36 * int'(s2_sel_r[0])
                              + 6 * int'(s2_sel_r[1]) + int'(s2_sel_r[2]));
    for (int k = 0; k < SYS_N; k++) begin
      e   = sys_color(4'(k));
      dot = int'(e[23:16]) * int'(s2_c_r[0]) + int'(e[15:8]) * int'(s2_c_r[1])
          + int'(e[7:0]) * int'(s2_c_r[2]);
      k2  = int'(e[23:16]) * int'(e[23:16]) + int'(e[15:8]) * int'(e[15:8])
          + int'(e[7:0]) * int'(e[7:0]);
      s3_t_nxt[k] = T_W'(k2 - 2 * dot);
    end
    for (int k = 0; k < GREY_N; k++) begin
      v = grey_level(k);
      s3_t_nxt[SYS_N+k] = T_W'(3 * v * v - 2 * v * int'(s2_sum_r));
    end
  end

  always_comb begin
    for (int k = 0; k < SYS_N; k++) begin
      s4_cand_nxt[k].dist_sq = DIST_W'(int'(s3_q_r) + int'(s3_t_r[k]));
      s4_cand_nxt[k].idx     = IDX_W'(k);
    end
    s4_cand_nxt[CUBE_SLOT] = s3_cube_r;
    for (int k = 0; k < GREY_N; k++) begin
      s4_cand_nxt[GREY_SLOT+k].dist_sq = DIST_W'(int'(s3_q_r) + int'(s3_t_r[SYS_N+k]));
      s4_cand_nxt[GREY_SLOT+k].idx     = IDX_W'(GREY_BASE + k);
    end
  end

  // Pad leaves carry an unreachable distance and sit right of all real ones.
  always_comb begin
    for (int k = 0; k < TREE_N; k++) begin
      if (k < CAND_N) leaf[k] = s4_cand_r[k];
      else            leaf[k] = '{dist_sq: '1, idx: '0};
    end
    for (int j = 0; j < 16; j++) begin
      s5_nxt[j] = pick(pick(leaf[4*j], leaf[4*j+1]), pick(leaf[4*j+2], leaf[4*j+3]));
    end
    for (int j = 0; j < 4; j++) begin
      s6_nxt[j] = pick(pick(s5_r[4*j], s5_r[4*j+1]), pick(s5_r[4*j+2], s5_r[4*j+3]));
    end
    s7_nxt = pick(pick(s6_r[0], s6_r[1]), pick(s6_r[2], s6_r[3]));
  end

  always_ff @(posedge clk) begin
    s1_c_r[0] <= in_red;
    s1_c_r[1] <= in_green;
    s1_c_r[2] <= in_blue;
    s2_sq_r   <= s2_sq_nxt;
    s2_sum_r  <= s2_sum_nxt;
    s2_sel_r  <= s2_sel_nxt;
    s2_dif_r  <= s2_dif_nxt;
    s2_c_r    <= s1_c_r;
    s3_q_r    <= s3_q_nxt;
    s3_cube_r <= s3_cube_nxt;
    s3_t_r    <= s3_t_nxt;
    s4_cand_r <= s4_cand_nxt;
    s5_r      <= s5_nxt;
    s6_r      <= s6_nxt;
    s7_r      <= s7_nxt;
  end

  assign out_valid         = vld_r[STAGES-1];
  assign out_palette_index = s7_r.idx;

  // every strobe traces back to an item accepted at the pipeline input
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, STAGES))
    else $error("result strobe without a matching accepted item");

  // duplicate entries 16 and 244 must lose to their lower twins 0 and 8
  a_dup_tie: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_palette_index != 8'd16 && out_palette_index != 8'd244))
    else $error("duplicate palette entry won over its lower twin");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for rgb_to_xterm256_nearest_unit: stimulus, nearest-color predictor and checks.
`default_nettype none
module tb;

  typedef enum int {CHK_OK, CHK_WRONG, CHK_STRAY} check_e;

  // Holds the palette indexes still due from the block, oldest first.
  class palette_board;
    logic [7:0] idx_due[$];
    int noted;
    int checked;

    function logic [7:0] cube_lvl(int k);
      case (k)
        0: return 8'h00;
        1: return 8'h5f;
        2: return 8'h87;
        3: return 8'haf;
        4: return 8'hd7;
        default: return 8'hff;
      endcase
    endfunction

    function logic [23:0] entry_color(int i);
      int n;
      logic [7:0] g;
      if (i < 16) begin
        case (i)
          0: return 24'h000000;
          1: return 24'h800000;
          2: return 24'h008000;
          3: return 24'h808000;
          4: return 24'h000080;
          5: return 24'h800080;
          6: return 24'h008080;
          7: return 24'hc0c0c0;
          8: return 24'h808080;
          9: return 24'hff0000;
          10: return 24'h00ff00;
          11: return 24'hffff00;
          12: return 24'h0000ff;
          13: return 24'hff00ff;
          14: return 24'h00ffff;
          default: return 24'hffffff;
        endcase
      end else if (i < 232) begin
        n = i - 16;
        return {cube_lvl(n / 36), cube_lvl((n / 6) % 6), cube_lvl(n % 6)};
      end
      g = 8'(8 + 10 * (i - 232));
      return {g, g, g};
    endfunction

    // Full search over all 256 entries; strict compare keeps the lowest index on ties.
    function logic [7:0] nearest_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int best;
      int dist_sq;
      int dr;
      int dg;
      int db;
      logic [23:0] e;
      logic [7:0] idx;
      best = 0;
      idx = 8'd0;
      for (int i = 0; i < 256; i++) begin
        e = entry_color(i);
        dr = int'(r) - int'(e[23:16]);
        dg = int'(g) - int'(e[15:8]);
        db = int'(b) - int'(e[7:0]);
        dist_sq = dr * dr + dg * dg + db * db;
        if (i == 0 || dist_sq < best) begin
          best = dist_sq;
          idx = 8'(i);
        end
      end
      return idx;
    endfunction

    function void note_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      idx_due.push_back(nearest_index(r, g, b));
      noted++;
    endfunction

    function check_e check_index(logic [7:0] got, output logic [7:0] want);
      want = 8'hxx;
      if (idx_due.size() == 0) return CHK_STRAY;
      want = idx_due.pop_front();
      checked++;
      return (got === want) ? CHK_OK : CHK_WRONG;
    endfunction

    function int pending();
      return idx_due.size();
    endfunction
  endclass

  localparam int RANDOM_N = 700;
  localparam int CALM_N   = 150;   // closing stretch with no gaps
  localparam int DRAIN_MAX = 200;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       out_valid;
  logic [7:0] out_palette_index;

  palette_board board = new;
  int         errors;
  int         directed_n;
  int         gap_pct;
  check_e     verdict;
  logic [7:0] want_idx;

  rgb_to_xterm256_nearest_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_palette_index(out_palette_index)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[rgb_to_xterm256_nearest_unit] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  // One item: optional idle burst, then hold start until the block takes it.
  task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    board.note_color(r, g, b);
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] c, input int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] edge_level();
    logic [7:0] lv[10] = '{8'd47, 8'd48, 8'd115, 8'd116, 8'd155, 8'd156,
                           8'd195, 8'd196, 8'd235, 8'd236};
    return lv[$urandom_range(0, 9)];
  endfunction

  task automatic send_random();
    logic [23:0] e;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  dup[6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'h81, 8'hff};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end
      4, 5: begin
        // close to some palette entry
        e = board.entry_color($urandom_range(0, 255));
        r = nudge(e[23:16], 3); g = nudge(e[15:8], 3); b = nudge(e[7:0], 3);
      end
      6: begin
        r = 8'($urandom);
        g = nudge(r, 2); b = nudge(r, 2);
      end
      7: begin
        // around the midpoints between cube levels
        r = edge_level(); g = edge_level(); b = edge_level();
      end
      8: begin
        // around black, mid grey and white, where duplicate entries tie
        r = dup[$urandom_range(0, 5)]; g = dup[$urandom_range(0, 5)];
        b = dup[$urandom_range(0, 5)];
      end
      default: begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = 8'($urandom); b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    endcase
    send_color(r, g, b);
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      verdict = board.check_index(out_palette_index, want_idx);
      if (verdict == CHK_STRAY)
        report_mismatch($sformatf("index %0d with no item outstanding", out_palette_index));
      else if (verdict == CHK_WRONG)
        report_mismatch($sformatf("palette_index %0d, want %0d", out_palette_index, want_idx));
    end
  end

  initial begin
    logic [23:0] fixed[23] = '{
      24'h000000, 24'hffffff, 24'h808080, 24'hc0c0c0, 24'h5f0000, 24'h870000,
      24'haf0000, 24'hd70000, 24'h080808, 24'heeeeee, 24'hff0000, 24'h00ff00,
      24'h0000ff, 24'h2f3073, 24'h749b9c, 24'hc3c4eb, 24'hec01fe, 24'haa55aa,
      24'h55aa55, 24'h7f7f7f, 24'h818181, 24'h040404, 24'hf6f6f6};
    int w;
    errors   = 0;
    gap_pct  = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_red   = 8'd0;
    in_green = 8'd0;
    in_blue  = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gap_pct = 25;
    foreach (fixed[i]) send_color(fixed[i][23:16], fixed[i][15:8], fixed[i][7:0]);
    directed_n = $size(fixed);

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n >= RANDOM_N - CALM_N) gap_pct = 0;
      else if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 12;
          default: gap_pct = 50;
        endcase
      end
      send_random();
    end
    @(negedge clk);
    start <= 1'b0;

    for (w = 0; w < DRAIN_MAX && board.pending() > 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending() > 0)
      report_mismatch($sformatf("%0d palette indexes never arrived", board.pending()));

    $display("Mapped %0d colors (%0d directed, %0d random) to the xterm palette",
             board.noted, directed_n, board.noted - directed_n);
    $display("Compared %0d palette indexes, %0d mismatches", board.checked, errors);
    if (errors == 0)
      $display("[rgb_to_xterm256_nearest_unit] OK");
    else
      $display("[rgb_to_xterm256_nearest_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
